// ----- sv/vnt_pkg.sv -----
// Shared widths, pipeline depths, register map and reset values for the
// vertex normal/tangent transform. No dependencies.
`default_nettype none

package vnt_pkg;

    // field formats
    localparam int POS_W   = 32;   // Q16.16
    localparam int DIR_W   = 16;   // Q2.14
    localparam int COEF_W  = 18;   // Q8.10
    localparam int ROW_W   = 3 * COEF_W;

    // configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_IDX_W  = 3;

    // internal datapath widths
    localparam int COFP_W  = 2 * COEF_W;          // cofactor partial product
    localparam int COF_W   = COFP_W + 1;          // cofactor entry
    localparam int PPROD_W = COEF_W + POS_W;      // position product
    localparam int PACC_W  = PPROD_W + 2;         // position sum
    localparam int TPROD_W = COEF_W + DIR_W;      // tangent product
    localparam int TVEC_W  = TPROD_W + 2;         // tangent direction
    localparam int NPROD_W = COF_W + DIR_W;       // normal product
    localparam int NVEC_W  = NPROD_W + 1;         // normal direction

    // normalizer widths
    localparam int MAG_W   = NVEC_W;              // magnitude before scaling
    localparam int M_W     = 30;                  // scaled magnitude, msb at bit 29
    localparam int SQP_W   = 2 * M_W;
    localparam int SQ_W    = SQP_W + 2;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int Q_W     = 15;
    localparam int FRAC_W  = 14;
    localparam int NUM_W   = M_W + FRAC_W + 2;
    localparam int TRIAL_W = 64;

    // pipeline depths
    localparam int FRONT_LAT = 5;
    localparam int NORM_LAT  = 5 + ROOT_W + 1 + Q_W + 1;
    localparam int PIPE_LAT  = FRONT_LAT + NORM_LAT;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0  = 3'd0,
        REG_ROW1  = 3'd1,
        REG_ROW2  = 3'd2,
        REG_OFF_X = 3'd3,
        REG_OFF_Y = 3'd4,
        REG_OFF_Z = 3'd5
    } cfg_reg_t;

    localparam logic [ROW_W-1:0] ROW0_RST = 54'd1024;
    localparam logic [ROW_W-1:0] ROW1_RST = 54'd268435456;
    localparam logic [ROW_W-1:0] ROW2_RST = 54'd4503599627370496;

endpackage

`default_nettype wire

// ----- sv/vnt_if.sv -----
// Stream channel interfaces for vertex beats and transformed vertex beats.
// Depends on vnt_pkg for field widths.
`default_nettype none

interface vnt_in_if;
    logic valid;
    logic ready;
    logic signed [vnt_pkg::POS_W-1:0] pos_x;
    logic signed [vnt_pkg::POS_W-1:0] pos_y;
    logic signed [vnt_pkg::POS_W-1:0] pos_z;
    logic signed [vnt_pkg::DIR_W-1:0] norm_x;
    logic signed [vnt_pkg::DIR_W-1:0] norm_y;
    logic signed [vnt_pkg::DIR_W-1:0] norm_z;
    logic signed [vnt_pkg::DIR_W-1:0] tan_x;
    logic signed [vnt_pkg::DIR_W-1:0] tan_y;
    logic signed [vnt_pkg::DIR_W-1:0] tan_z;
    logic signed [vnt_pkg::DIR_W-1:0] tan_sign;

    modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    tan_x, tan_y, tan_z, tan_sign, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  tan_x, tan_y, tan_z, tan_sign, output ready);
endinterface

interface vnt_out_if;
    logic valid;
    logic ready;
    logic signed [vnt_pkg::POS_W-1:0] out_pos_x;
    logic signed [vnt_pkg::POS_W-1:0] out_pos_y;
    logic signed [vnt_pkg::POS_W-1:0] out_pos_z;
    logic signed [vnt_pkg::DIR_W-1:0] out_norm_x;
    logic signed [vnt_pkg::DIR_W-1:0] out_norm_y;
    logic signed [vnt_pkg::DIR_W-1:0] out_norm_z;
    logic signed [vnt_pkg::DIR_W-1:0] out_tan_x;
    logic signed [vnt_pkg::DIR_W-1:0] out_tan_y;
    logic signed [vnt_pkg::DIR_W-1:0] out_tan_z;
    logic signed [vnt_pkg::DIR_W-1:0] out_tan_sign;

    modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_norm_x,
                    out_norm_y, out_norm_z, out_tan_x, out_tan_y, out_tan_z,
                    out_tan_sign, input ready);
    modport sink (input valid, out_pos_x, out_pos_y, out_pos_z, out_norm_x,
                  out_norm_y, out_norm_z, out_tan_x, out_tan_y, out_tan_z,
                  out_tan_sign, output ready);
endinterface

`default_nettype wire

// ----- sv/vertex_normal_tangent_transform.sv -----
// Top level: APB register file, affine position transform, cofactor normal
// transform and tangent transform. Depends on vnt_pkg, vnt_if, vnt_normalize.
`default_nettype none

//  channel   | kind          | beat contents
//  ----------+---------------+---------------------------------------------
//  vtx_in    | valid/ready   | position Q16.16, normal, tangent, handedness
//  vtx_out   | valid/ready   | saturated position, unit normal, unit tangent
//  apb       | psel/penable  | 6 registers, 64-bit data, byte address 8*i
//
//  One vertex beat enters per cycle while the output is not held; the depth
//  is set by the 31-stage square root and the 15-stage divider of the renormalizers.
//  The whole pipeline advances together; when the output beat is held by
//  the sink, every stage holds and vtx_in.ready drops, so nothing is lost.
//  Reset clears the valid bits, zeroes the offsets and loads diagonal row defaults of 1.0, 1.0 and 64.0.
//  The cofactor matrix is registered behind the row registers, through cofp_reg and then cof_reg.

module vertex_normal_tangent_transform (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [vnt_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [vnt_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic      [vnt_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                     pready,
    vnt_in_if.sink                                   vtx_in,
    vnt_out_if.source                                vtx_out
);

    localparam int POS_W   = vnt_pkg::POS_W;
    localparam int DIR_W   = vnt_pkg::DIR_W;
    localparam int COEF_W  = vnt_pkg::COEF_W;
    localparam int ROW_W   = vnt_pkg::ROW_W;
    localparam int PACC_W  = vnt_pkg::PACC_W;
    localparam int LAT     = vnt_pkg::PIPE_LAT;
    localparam int FRONT   = vnt_pkg::FRONT_LAT;

    // ---------------------------------------------------------------
    // Register file
    // ---------------------------------------------------------------
    logic [ROW_W-1:0]        row_reg [3];
    logic signed [POS_W-1:0] off_reg [3];
    vnt_pkg::cfg_reg_t       cfg_idx;
    logic                    cfg_wr;

    assign cfg_idx = vnt_pkg::cfg_reg_t'(paddr[vnt_pkg::CFG_ADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= vnt_pkg::ROW0_RST;
            row_reg[1] <= vnt_pkg::ROW1_RST;
            row_reg[2] <= vnt_pkg::ROW2_RST;
            off_reg[0] <= '0;
            off_reg[1] <= '0;
            off_reg[2] <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                vnt_pkg::REG_ROW0:  row_reg[0] <= pwdata[ROW_W-1:0];
                vnt_pkg::REG_ROW1:  row_reg[1] <= pwdata[ROW_W-1:0];
                vnt_pkg::REG_ROW2:  row_reg[2] <= pwdata[ROW_W-1:0];
                vnt_pkg::REG_OFF_X: off_reg[0] <= pwdata[POS_W-1:0];
                vnt_pkg::REG_OFF_Y: off_reg[1] <= pwdata[POS_W-1:0];
                vnt_pkg::REG_OFF_Z: off_reg[2] <= pwdata[POS_W-1:0];
                default: ;  // drop writes beyond the map
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            vnt_pkg::REG_ROW0:  prdata = 64'(row_reg[0]);
            vnt_pkg::REG_ROW1:  prdata = 64'(row_reg[1]);
            vnt_pkg::REG_ROW2:  prdata = 64'(row_reg[2]);
            vnt_pkg::REG_OFF_X: prdata = 64'(unsigned'(off_reg[0]));
            vnt_pkg::REG_OFF_Y: prdata = 64'(unsigned'(off_reg[1]));
            vnt_pkg::REG_OFF_Z: prdata = 64'(unsigned'(off_reg[2]));
            default:            prdata = '0;
        endcase
    end

    // matrix entries, row-major
    logic signed [COEF_W-1:0] a [9];
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                a[r*3+c] = row_reg[r][c*COEF_W +: COEF_W];
    end

    // Cofactor matrix: products, then differences. Free running off the
    // registers; items reach the normal multiply late enough to see it settled.
    logic signed [vnt_pkg::COFP_W-1:0] cofp_reg [9][2];
    logic signed [vnt_pkg::COF_W-1:0]  cof_reg  [9];

    always_ff @(posedge clk)
    begin
        cofp_reg[0][0] <= a[4] * a[8];  cofp_reg[0][1] <= a[5] * a[7];
        cofp_reg[1][0] <= a[5] * a[6];  cofp_reg[1][1] <= a[3] * a[8];
        cofp_reg[2][0] <= a[3] * a[7];  cofp_reg[2][1] <= a[4] * a[6];
        cofp_reg[3][0] <= a[2] * a[7];  cofp_reg[3][1] <= a[1] * a[8];
        cofp_reg[4][0] <= a[0] * a[8];  cofp_reg[4][1] <= a[2] * a[6];
        cofp_reg[5][0] <= a[1] * a[6];  cofp_reg[5][1] <= a[0] * a[7];
        cofp_reg[6][0] <= a[1] * a[5];  cofp_reg[6][1] <= a[2] * a[4];
        cofp_reg[7][0] <= a[2] * a[3];  cofp_reg[7][1] <= a[0] * a[5];
        cofp_reg[8][0] <= a[0] * a[4];  cofp_reg[8][1] <= a[1] * a[3];
        for (int k = 0; k < 9; k++)
            cof_reg[k] <= vnt_pkg::COF_W'(cofp_reg[k][0]) - vnt_pkg::COF_W'(cofp_reg[k][1]);
    end

    // ---------------------------------------------------------------
    // Pipeline control: all stages advance together
    // ---------------------------------------------------------------
    logic [LAT:1] v_reg;
    logic         en;

    assign en           = !v_reg[LAT] || vtx_out.ready;
    assign vtx_in.ready = en;
    assign vtx_out.valid = v_reg[LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[LAT-1:1], vtx_in.valid};
    end

    // stage 1: capture the beat
    logic signed [POS_W-1:0] p1_reg [3];
    logic signed [DIR_W-1:0] n_reg  [1:3][3];
    logic signed [DIR_W-1:0] t1_reg [3];
    logic signed [DIR_W-1:0] sign_reg [1:LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg[0]   <= vtx_in.pos_x;
            p1_reg[1]   <= vtx_in.pos_y;
            p1_reg[2]   <= vtx_in.pos_z;
            n_reg[1][0] <= vtx_in.norm_x;
            n_reg[1][1] <= vtx_in.norm_y;
            n_reg[1][2] <= vtx_in.norm_z;
            t1_reg[0]   <= vtx_in.tan_x;
            t1_reg[1]   <= vtx_in.tan_y;
            t1_reg[2]   <= vtx_in.tan_z;
            sign_reg[1] <= vtx_in.tan_sign;
            n_reg[2]    <= n_reg[1];
            n_reg[3]    <= n_reg[2];
            for (int s = 2; s <= LAT; s++)
                sign_reg[s] <= sign_reg[s-1];
        end
    end

    // stage 2: position and tangent products
    logic signed [vnt_pkg::PPROD_W-1:0] pp_reg [3][3];
    logic signed [vnt_pkg::TPROD_W-1:0] tp_reg [3][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                begin
                    pp_reg[r][c] <= a[r*3+c] * p1_reg[c];
                    tp_reg[r][c] <= a[r*3+c] * t1_reg[c];
                end
        end
    end

    // stage 3: position sums with offset, tangent sums
    logic signed [PACC_W-1:0]          pacc_reg [3];
    logic signed [vnt_pkg::TVEC_W-1:0] td_reg   [3:5][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                pacc_reg[r] <= PACC_W'(pp_reg[r][0]) + PACC_W'(pp_reg[r][1])
                             + PACC_W'(pp_reg[r][2]) + (PACC_W'(off_reg[r]) <<< 10);
                td_reg[3][r] <= vnt_pkg::TVEC_W'(tp_reg[r][0])
                              + vnt_pkg::TVEC_W'(tp_reg[r][1])
                              + vnt_pkg::TVEC_W'(tp_reg[r][2]);
            end
            td_reg[4] <= td_reg[3];
            td_reg[5] <= td_reg[4];
        end
    end

    // stage 4: round and saturate position; normal products
    logic signed [PACC_W-1:0]           prnd [3];
    logic signed [POS_W-1:0]            psat [3];
    logic signed [POS_W-1:0]            pos_reg [4:LAT][3];
    logic signed [vnt_pkg::NPROD_W-1:0] np_reg [3][3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            prnd[r] = (pacc_reg[r] + PACC_W'(512)) >>> 10;
            if (prnd[r] > PACC_W'(32'sh7fffffff))
                psat[r] = 32'sh7fffffff;
            else if (prnd[r] < -PACC_W'(33'sh080000000))
                psat[r] = 32'sh80000000;
            else
                psat[r] = prnd[r][POS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg[4] <= psat;
            for (int s = 5; s <= LAT; s++)
                pos_reg[s] <= pos_reg[s-1];
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    np_reg[r][c] <= cof_reg[r*3+c] * n_reg[3][c];
        end
    end

    // stage 5: normal direction sums
    logic signed [vnt_pkg::MAG_W-1:0] nd_reg [3];
    logic signed [vnt_pkg::MAG_W-1:0] tvec   [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                nd_reg[r] <= vnt_pkg::MAG_W'(np_reg[r][0]) + vnt_pkg::MAG_W'(np_reg[r][1])
                           + vnt_pkg::MAG_W'(np_reg[r][2]);
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            tvec[r] = vnt_pkg::MAG_W'(td_reg[FRONT][r]);
    end

    // renormalizers
    logic signed [DIR_W-1:0] nu [3];
    logic signed [DIR_W-1:0] tu [3];

    vnt_normalize u_norm_n (
        .clk      (clk),
        .en       (en),
        .vec      (nd_reg),
        .unit_vec (nu)
    );

    vnt_normalize u_norm_t (
        .clk      (clk),
        .en       (en),
        .vec      (tvec),
        .unit_vec (tu)
    );

    assign vtx_out.out_pos_x    = pos_reg[LAT][0];
    assign vtx_out.out_pos_y    = pos_reg[LAT][1];
    assign vtx_out.out_pos_z    = pos_reg[LAT][2];
    assign vtx_out.out_norm_x   = nu[0];
    assign vtx_out.out_norm_y   = nu[1];
    assign vtx_out.out_norm_z   = nu[2];
    assign vtx_out.out_tan_x    = tu[0];
    assign vtx_out.out_tan_y    = tu[1];
    assign vtx_out.out_tan_z    = tu[2];
    assign vtx_out.out_tan_sign = sign_reg[LAT];

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_out.valid |->
            vtx_out.out_norm_x >= -16'sd16384 && vtx_out.out_norm_x <= 16'sd16384 &&
            vtx_out.out_norm_y >= -16'sd16384 && vtx_out.out_norm_y <= 16'sd16384 &&
            vtx_out.out_norm_z >= -16'sd16384 && vtx_out.out_norm_z <= 16'sd16384)
        else $error("normal component out of unit range");

    a_tan_range: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_out.valid |->
            vtx_out.out_tan_x >= -16'sd16384 && vtx_out.out_tan_x <= 16'sd16384 &&
            vtx_out.out_tan_y >= -16'sd16384 && vtx_out.out_tan_y <= 16'sd16384 &&
            vtx_out.out_tan_z >= -16'sd16384 && vtx_out.out_tan_z <= 16'sd16384)
        else $error("tangent component out of unit range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline moved while output was held");

endmodule

`default_nettype wire

// ----- sv/vnt_normalize.sv -----
// Pipelined renormalizer: scale, square-sum, bit-per-stage square root,
// bit-per-stage rounded division. Depends on vnt_pkg.
`default_nettype none

module vnt_normalize (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [vnt_pkg::MAG_W-1:0]  vec [3],
    output logic signed [vnt_pkg::DIR_W-1:0]       unit_vec [3]
);

    localparam int MAG_W  = vnt_pkg::MAG_W;
    localparam int M_W    = vnt_pkg::M_W;
    localparam int ROOT_W = vnt_pkg::ROOT_W;
    localparam int SQ_W   = vnt_pkg::SQ_W;
    localparam int Q_W    = vnt_pkg::Q_W;
    localparam int NUM_W  = vnt_pkg::NUM_W;
    localparam int TW     = vnt_pkg::TRIAL_W;
    localparam int NGRP   = (MAG_W - 1) / 8;
    // scaled magnitudes are carried until the root leaves the last sqrt stage
    localparam int LAST   = 2 + ROOT_W;

    // stage 1: sign and magnitude
    logic [MAG_W-1:0] mag1_reg [3];
    logic [MAG_W-1:0] or1_reg;
    logic [2:0]       neg1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg1_reg[i] <= vec[i][MAG_W-1];
                mag1_reg[i] <= vec[i][MAG_W-1] ? MAG_W'(-vec[i]) : MAG_W'(vec[i]);
            end
            or1_reg <= (vec[0][MAG_W-1] ? MAG_W'(-vec[0]) : MAG_W'(vec[0]))
                     | (vec[1][MAG_W-1] ? MAG_W'(-vec[1]) : MAG_W'(vec[1]))
                     | (vec[2][MAG_W-1] ? MAG_W'(-vec[2]) : MAG_W'(vec[2]));
        end
    end

    // stage 2: coarse left shift by whole bytes
    logic [MAG_W-1:0] mag2_reg [3];
    logic [MAG_W-1:0] or2_reg;
    logic [2:0]       neg2_reg;
    logic [5:0]       coarse_sh;

    always_comb
    begin
        coarse_sh = '0;
        for (int j = 1; j <= NGRP; j++)
        begin
            if ((or1_reg >> (MAG_W - 8 * j)) == '0)
                coarse_sh = 6'(8 * j);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                mag2_reg[i] <= mag1_reg[i] << coarse_sh;
            or2_reg  <= or1_reg << coarse_sh;
            neg2_reg <= neg1_reg;
        end
    end

    // stage 3: fine shift, msb lands on bit 29 of the kept field
    logic [2:0]       fine_sh;
    logic [MAG_W-1:0] fine_v [3];

    always_comb
    begin
        fine_sh = '0;
        for (int j = 1; j <= 7; j++)
        begin
            if (or2_reg[MAG_W-1 -: 8] >> (8 - j) == '0)
                fine_sh = 3'(j);
        end
        for (int i = 0; i < 3; i++)
            fine_v[i] = mag2_reg[i] << fine_sh;
    end

    logic [M_W-1:0] m_reg    [0:LAST][3];
    logic [2:0]     neg_reg  [0:LAST];
    logic           zero_reg [0:LAST];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                m_reg[0][i] <= fine_v[i][MAG_W-1 -: M_W];
            neg_reg[0]  <= neg2_reg;
            zero_reg[0] <= (or2_reg == '0);
        end
    end

    // stage 4: squares; stage 5: their sum
    logic [2*M_W-1:0] sqp_reg [3];
    logic [SQ_W-1:0]  rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                sqp_reg[i] <= m_reg[0][i] * m_reg[0][i];
            rem_reg[0]  <= SQ_W'(sqp_reg[0]) + SQ_W'(sqp_reg[1]) + SQ_W'(sqp_reg[2]);
            root_reg[0] <= '0;
        end
    end

    // carry magnitudes and flags alongside the square root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 1; s <= LAST; s++)
            begin
                m_reg[s]    <= m_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
            end
        end
    end

    // square root, one result bit per stage, msb first
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        localparam int B = ROOT_W - 1 - k;
        logic [TW-1:0] trial;
        logic          take;

        always_comb
        begin
            trial = (TW'(root_reg[k]) << (B + 1)) + (TW'(1) << (2 * B));
            take  = TW'(rem_reg[k]) >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= take ? SQ_W'(TW'(rem_reg[k]) - trial) : rem_reg[k];
                root_reg[k+1] <= take ? (root_reg[k] | (ROOT_W'(1) << B)) : root_reg[k];
            end
        end
    end

    // division setup: numerator = mag * 2^14 + len / 2
    logic [NUM_W-1:0]  drem_reg [0:Q_W][3];
    logic [Q_W-1:0]    quo_reg  [0:Q_W][3];
    logic [ROOT_W-1:0] len_reg  [0:Q_W];
    logic [2:0]        dneg_reg [0:Q_W];
    logic              dzero_reg [0:Q_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                drem_reg[0][i] <= (NUM_W'(m_reg[LAST][i]) << vnt_pkg::FRAC_W)
                                + NUM_W'(root_reg[ROOT_W] >> 1);
                quo_reg[0][i]  <= '0;
            end
            len_reg[0]   <= root_reg[ROOT_W];
            dneg_reg[0]  <= neg_reg[LAST];
            dzero_reg[0] <= zero_reg[LAST];
        end
    end

    // long division, one quotient bit per stage
    for (genvar k = 0; k < Q_W; k++)
    begin : g_div
        localparam int B = Q_W - 1 - k;
        logic [NUM_W-1:0] dv;

        assign dv = NUM_W'(len_reg[k]) << B;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (drem_reg[k][i] >= dv)
                    begin
                        drem_reg[k+1][i] <= drem_reg[k][i] - dv;
                        quo_reg[k+1][i]  <= quo_reg[k][i] | (Q_W'(1) << B);
                    end
                    else
                    begin
                        drem_reg[k+1][i] <= drem_reg[k][i];
                        quo_reg[k+1][i]  <= quo_reg[k][i];
                    end
                end
                len_reg[k+1]   <= len_reg[k];
                dneg_reg[k+1]  <= dneg_reg[k];
                dzero_reg[k+1] <= dzero_reg[k];
            end
        end
    end

    // apply sign; quotient never exceeds 2^14 so no clamp is reachable
    logic signed [vnt_pkg::DIR_W-1:0] unit_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dzero_reg[Q_W])
                    unit_reg[i] <= '0;
                else if (dneg_reg[Q_W][i])
                    unit_reg[i] <= -$signed({1'b0, quo_reg[Q_W][i]});
                else
                    unit_reg[i] <= $signed({1'b0, quo_reg[Q_W][i]});
            end
        end
    end

    assign unit_vec = unit_reg;

endmodule

`default_nettype wire
